// File: design/lbs_pkg.sv
package lbs_pkg;
    localparam int NumJoints = 32;
    localparam int FracBits = 16;
    localparam int MatWords = 12;
    localparam int TableDepth = NumJoints * MatWords;
    localparam int AddrW = $clog2(TableDepth);
    localparam int WeightFrac = 16;

    localparam logic [1:0] FUNC_POSE = 2'd0;
    localparam logic [1:0] FUNC_BIND = 2'd1;
    localparam logic [1:0] FUNC_TERM = 2'd2;

    // classified command from the front end to the back end
    typedef struct packed {
        logic        is_load;
        logic        is_pose;
        logic        do_term;
        logic        last;
        logic [AddrW-1:0] base;
        logic [31:0] value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [16:0] weight;
    } t_cmd;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction
endpackage

// File: design/lbs_front.sv
module lbs_front
    import lbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_joint,
    input  logic [3:0]  i_element,
    input  logic [31:0] i_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [16:0] i_weight,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cmd        o_cmd
);
    // two-entry queue
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_c;
    logic w_push, w_pop, w_jok;

    always_comb begin
        w_jok = 32'(i_joint) < NumJoints;
        w_c = '0;
        w_c.is_load = (i_func == FUNC_POSE || i_func == FUNC_BIND) && w_jok
                      && i_element < 4'(MatWords);
        w_c.is_pose = i_func == FUNC_POSE;
        w_c.do_term = i_func == FUNC_TERM && w_jok;
        w_c.last = i_func == FUNC_TERM && i_last;
        w_c.base = AddrW'(32'(i_joint) * MatWords)
                   + (w_c.is_load ? AddrW'(i_element) : AddrW'(0));
        w_c.value = i_value;
        w_c.pos_x = i_pos_x;
        w_c.pos_y = i_pos_y;
        w_c.pos_z = i_pos_z;
        w_c.weight = i_weight;
    end

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd = r_q[r_rp];
    assign w_push = i_valid && o_ready && (w_c.is_load || w_c.do_term || w_c.last);
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_c;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// File: design/lbs_back.sv
module lbs_back
    import lbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [95:0] o_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_WGT  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [31:0] r_pose [TableDepth];
    logic [31:0] r_bind [TableDepth];
    logic [31:0] r_pd, r_bd;

    logic [2:0] r_st;
    t_cmd r_cmd;
    logic r_pass;            // 0 bind-inverse, 1 pose
    logic [1:0] r_row, r_col; // col 3 = translation
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_u [3];
    logic signed [63:0] r_acc, r_prod;
    logic signed [47:0] r_sum [3];
    logic r_valid;
    logic [95:0] r_out;

    logic [AddrW-1:0] w_addr;
    logic signed [31:0] w_m, w_in, w_r;
    logic signed [63:0] w_rnd;

    assign w_addr = r_cmd.base + AddrW'({r_row, r_col});
    assign w_m = r_pass ? r_pd : r_bd;
    assign w_in = r_v[r_col];
    assign w_rnd = sat_add64(r_acc, 64'sd1 <<< (FracBits - 1)) >>> FracBits;
    assign w_r = sat32(w_rnd);
    assign o_ready = r_st == S_IDLE;
    assign o_valid = r_valid;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_cmd.is_load) begin
            if (i_cmd.is_pose) r_pose[i_cmd.base] <= i_cmd.value;
            else r_bind[i_cmd.base] <= i_cmd.value;
        end
        r_pd <= r_pose[w_addr];
        r_bd <= r_bind[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= 1'b0;
            for (int k = 0; k < 3; k++) r_sum[k] <= '0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_cmd;
                    r_v[0] <= i_cmd.pos_x;
                    r_v[1] <= i_cmd.pos_y;
                    r_v[2] <= i_cmd.pos_z;
                    r_pass <= 1'b0;
                    r_row <= 2'd0;
                    r_col <= 2'd3;
                    if (i_cmd.do_term) r_st <= S_RD;
                    else if (i_cmd.last) r_st <= S_EMIT;
                end
                S_RD: r_st <= S_MUL;
                S_MUL: begin
                    if (r_col == 2'd3)
                        r_acc <= 64'(w_m) <<< FracBits;
                    else
                        r_prod <= w_m * w_in;
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    if (r_col != 2'd3) r_acc <= sat_add64(r_acc, r_prod);
                    if (r_col == 2'd2) begin
                        r_st <= S_WGT;
                    end else begin
                        r_col <= r_col == 2'd3 ? 2'd0 : r_col + 2'd1;
                        r_st <= S_RD;
                    end
                end
                S_WGT: begin
                    // row finished
                    r_u[r_row] <= w_r;
                    r_col <= 2'd3;
                    r_st <= S_RD;
                    if (r_row == 2'd2) begin
                        r_row <= 2'd0;
                        if (!r_pass) begin
                            r_pass <= 1'b1;
                            r_v[0] <= r_u[0];
                            r_v[1] <= r_u[1];
                            r_v[2] <= w_r;
                        end else begin
                            r_st <= S_SUM;
                        end
                    end else begin
                        r_row <= r_row + 2'd1;
                    end
                end
                S_SUM: begin
                    // one coordinate per cycle through r_row
                    logic signed [49:0] p;
                    logic signed [49:0] s;
                    p = (50'(r_row == 2'd2 ? w_r : r_u[r_row]) * $signed({33'd0, r_cmd.weight})
                         + 50'sd32768) >>> WeightFrac;
                    s = 50'(r_sum[r_row]) + p;
                    if (s > 50'sh7fffffffffff) r_sum[r_row] <= 48'sh7fffffffffff;
                    else if (s < -50'sh800000000000) r_sum[r_row] <= 48'sh800000000000;
                    else r_sum[r_row] <= s[47:0];
                    if (r_row == 2'd2) r_st <= r_cmd.last ? S_EMIT : S_IDLE;
                    else r_row <= r_row + 2'd1;
                end
                S_EMIT: if (!r_valid) begin
                    for (int k = 0; k < 3; k++) begin
                        r_out[32*k +: 32] <= sat32(64'(r_sum[k]));
                        r_sum[k] <= '0;
                    end
                    r_valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/linear_blend_skinning.sv
// linear blend skinning: load transfers (tuser 0 pose, 1 bind-inverse) write one
// element of a joint's 3x4 matrix; term transfers (tuser 2) add weight * pose *
// bind-inverse * vertex into saturating 48-bit sums, and tlast on a term transfer
// emits the sums saturated to 32 bits. a front queue classifies transfers; the back
// end runs each term on one 32x32 multiplier, reading, multiplying and accumulating
// each matrix element in turn and rounding each row, then adding the weighted
// coordinates; it takes no new command, load included, until it is back in idle.
module linear_blend_skinning
    import lbs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint[4:0], element[8:5], value[40:9], pos_x, pos_y, pos_z, weight[153:137]
    input  logic [159:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,  // func
    input  logic         s_axis_tlast,  // last_term
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_axis_tdata
);
    logic w_qv, w_qr;
    t_cmd w_cmd;
    logic [5:0] w_pad;

    assign w_pad = s_axis_tdata[159:154];

    lbs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_func(s_axis_tuser), .i_joint(s_axis_tdata[4:0]),
        .i_element(s_axis_tdata[8:5]), .i_value(s_axis_tdata[40:9]),
        .i_pos_x(s_axis_tdata[72:41]), .i_pos_y(s_axis_tdata[104:73]),
        .i_pos_z(s_axis_tdata[136:105]), .i_weight(s_axis_tdata[153:137]),
        .i_last(s_axis_tlast | (&w_pad & 1'b0)),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_cmd)
    );

    lbs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );
endmodule
